@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation and status codes, and sequencer states for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int MODE_BITS         = 4;
   localparam int NUM_BITS          = 32;
   localparam int DEN_BITS          = 31;
   localparam int MAG_BITS          = 32;
   localparam int WIDE_BITS         = 2 * MAG_BITS;
   localparam int SHIFT_BITS        = $clog2(WIDE_BITS);

   typedef logic [MODE_BITS-1:0] mode_type;
   typedef logic [MAG_BITS-1:0]  mag_type;
   typedef logic [WIDE_BITS-1:0] wide_type;

   localparam mode_type MODE_NORM = 4'd0;
   localparam mode_type MODE_ADD  = 4'd1;
   localparam mode_type MODE_SUB  = 4'd2;
   localparam mode_type MODE_MUL  = 4'd3;
   localparam mode_type MODE_DIV  = 4'd4;
   localparam mode_type MODE_CMP  = 4'd5;
   localparam mode_type MODE_NEG  = 4'd6;
   localparam mode_type MODE_INC  = 4'd7;
   localparam mode_type MODE_DEC  = 4'd8;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_ZERO = 2'd1,
      STAT_OVF  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD1,
      ST_PROD2,
      ST_PROD3,
      ST_COMBINE,
      ST_GCD,
      ST_NSTART,
      ST_NWAIT,
      ST_DSTART,
      ST_DWAIT,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ rtl/rau_if.sv @@
// ----------------------------------------------------------------------------
// rau_if
// Request and response channels of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_req_if;
   import rau_pkg::*;

   logic                        valid;
   logic                        ready;
   mode_type                    mode;
   logic signed [NUM_BITS-1:0]  left_num;
   logic signed [NUM_BITS-1:0]  left_den;
   logic signed [NUM_BITS-1:0]  right_num;
   logic [DEN_BITS-1:0]         right_den;

   modport source (output valid, mode, left_num, left_den, right_num, right_den,
                   input ready);
   modport sink (input valid, mode, left_num, left_den, right_num, right_den,
                 output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [NUM_BITS-1:0]  result_num;
   logic [DEN_BITS-1:0]         result_den;
   logic                        is_less;
   logic                        is_equal;
   status_type                  status;

   modport source (output valid, result_num, result_den, is_less, is_equal, status,
                   input ready);
   modport sink (input valid, result_num, result_den, is_less, is_equal, status,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/rational_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Fraction ALU: normalize, add, subtract, multiply, divide, compare, negate,
// increment and decrement, with the result reduced by a binary gcd.
//
//   channel  dir  role                   handshake
//   req_ch   in   operation and operands valid/ready
//   rsp_ch   out  reduced fraction       valid/ready, registered
//
// one request at a time; error and undefined operations go straight to the
// finish state and compare skips the gcd and the divider; for the rest the time
// is set by the binary gcd loop (one shift or subtract per cycle)
// and the restoring divider, run once for each of the two quotients
// reset is synchronous and clears the sequencer and the response valid
// a finished result waits in the sequencer until the response register frees
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit_core #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);
   import rau_pkg::*;

   localparam wide_type LIM    = WIDE_BITS'(1) << (WORD_BITS - 1);
   localparam wide_type LIM_M1 = LIM - 1'b1;

   state_type state_ff, state_in;

   // operands
   mode_type mode_ff, mode_in;
   logic     lneg_ff, lneg_in;
   logic     rneg_ff, rneg_in;
   mag_type  lmag_ff, lmag_in;
   mag_type  ld_ff, ld_in;
   mag_type  rmag_ff, rmag_in;
   mag_type  rd_ff, rd_in;

   // products and reduction
   wide_type              p_ff, p_in;
   wide_type              q_ff, q_in;
   wide_type              r_ff, r_in;
   logic                  nneg_ff, nneg_in;
   wide_type              nmag_ff, nmag_in;
   wide_type              dmag_ff, dmag_in;
   wide_type              ga_ff, ga_in;
   wide_type              gb_ff, gb_in;
   logic [SHIFT_BITS-1:0] gk_ff, gk_in;
   wide_type              g_ff, g_in;
   wide_type              nq_ff, nq_in;
   wide_type              dq_ff, dq_in;

   // working result
   logic signed [NUM_BITS-1:0] out_num_ff, out_num_in;
   logic [DEN_BITS-1:0]        out_den_ff, out_den_in;
   logic                       out_lt_ff, out_lt_in;
   logic                       out_eq_ff, out_eq_in;
   status_type                 out_st_ff, out_st_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [NUM_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_BITS-1:0]        rsp_den_ff, rsp_den_in;
   logic                       rsp_lt_ff, rsp_lt_in;
   logic                       rsp_eq_ff, rsp_eq_in;
   status_type                 rsp_st_ff, rsp_st_in;

   logic     accept;
   logic     load;
   logic     div_start;
   wide_type div_dividend;
   logic     div_done;
   wide_type div_quo;

   // request decode
   mag_type ln_raw, ldr_raw, rn_raw;
   mag_type ln_mag, ldr_mag, rn_mag;
   logic    ln_neg, ldr_neg, rn_neg;
   logic    undef_mode, zero_err;

   // shared multiplier
   mag_type  mul_a, mul_b;
   wide_type mul_p;

   // signed add of p and q
   logic               bneg;
   wide_type           s_sum;
   logic [WIDE_BITS:0] s_diff;
   wide_type           s_rev;
   logic               s_neg;
   wide_type           s_mag;
   logic               s_zero;

   // gcd step
   logic     ga_zero, g_same, g_done;
   wide_type g_val;

   // range check
   logic              c_neg, c_ovf;
   logic [NUM_BITS-1:0] c_num;

   assign accept = req_ch.valid && req_ch.ready;
   assign load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      ln_raw     = mag_type'(req_ch.left_num);
      ldr_raw    = mag_type'(req_ch.left_den);
      rn_raw     = mag_type'(req_ch.right_num);
      ln_neg     = ln_raw[MAG_BITS-1];
      ldr_neg    = ldr_raw[MAG_BITS-1];
      rn_neg     = rn_raw[MAG_BITS-1];
      ln_mag     = ln_neg ? (~ln_raw + 1'b1) : ln_raw;
      ldr_mag    = ldr_neg ? (~ldr_raw + 1'b1) : ldr_raw;
      rn_mag     = rn_neg ? (~rn_raw + 1'b1) : rn_raw;
      undef_mode = req_ch.mode > MODE_DEC;
      zero_err   = (ldr_raw == '0)
                || ((req_ch.mode >= MODE_ADD) && (req_ch.mode <= MODE_CMP)
                    && (req_ch.right_den == '0))
                || ((req_ch.mode == MODE_DIV) && (rn_raw == '0));
   end

   always_comb begin
      mul_a = ld_ff;
      mul_b = mag_type'(1);
      case (state_ff)
         ST_PROD1: begin
            mul_a = lmag_ff;
            case (mode_ff)
               MODE_ADD, MODE_SUB, MODE_DIV, MODE_CMP: mul_b = rd_ff;
               MODE_MUL:                               mul_b = rmag_ff;
               default:                                mul_b = mag_type'(1);
            endcase
         end
         ST_PROD2: begin
            case (mode_ff)
               MODE_ADD, MODE_SUB, MODE_DIV, MODE_CMP: mul_b = rmag_ff;
               MODE_MUL:                               mul_b = rd_ff;
               default:                                mul_b = mag_type'(1);
            endcase
         end
         ST_PROD3: mul_b = rd_ff;
         default:  mul_b = mag_type'(1);
      endcase
      mul_p = WIDE_BITS'(mul_a) * WIDE_BITS'(mul_b);
   end

   always_comb begin
      case (mode_ff)
         MODE_ADD: bneg = rneg_ff;
         MODE_SUB: bneg = !rneg_ff;
         MODE_CMP: bneg = !rneg_ff;
         MODE_DEC: bneg = 1'b1;
         default:  bneg = 1'b0;
      endcase
      s_sum  = p_ff + q_ff;
      s_diff = {1'b0, p_ff} - {1'b0, q_ff};
      s_rev  = q_ff - p_ff;
      if (lneg_ff == bneg) begin
         s_neg = lneg_ff;
         s_mag = s_sum;
      end else if (!s_diff[WIDE_BITS]) begin
         s_neg = lneg_ff;
         s_mag = s_diff[WIDE_BITS-1:0];
      end else begin
         s_neg = bneg;
         s_mag = s_rev;
      end
      s_zero = s_mag == '0;
   end

   always_comb begin
      ga_zero = ga_ff == '0;
      g_same  = ga_ff == gb_ff;
      g_done  = ga_zero || g_same;
      g_val   = (ga_zero ? gb_ff : ga_ff) << gk_ff;
   end

   always_comb begin
      c_neg = nneg_ff && (nq_ff != '0);
      c_ovf = (dq_ff > LIM_M1) || (nq_ff > (c_neg ? LIM : LIM_M1));
      c_num = c_neg ? (~nq_ff[NUM_BITS-1:0] + 1'b1) : nq_ff[NUM_BITS-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (undef_mode || zero_err) ? ST_FINISH : ST_PROD1;
            end
         end
         ST_PROD1: state_in = ST_PROD2;
         ST_PROD2: begin
            state_in = (mode_ff == MODE_ADD || mode_ff == MODE_SUB) ? ST_PROD3
                                                                     : ST_COMBINE;
         end
         ST_PROD3:   state_in = ST_COMBINE;
         ST_COMBINE: state_in = (mode_ff == MODE_CMP) ? ST_FINISH : ST_GCD;
         ST_GCD: begin
            if (g_done) begin
               state_in = ST_NSTART;
            end
         end
         ST_NSTART: state_in = ST_NWAIT;
         ST_NWAIT: begin
            if (div_done) begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = ST_FINISH;
         ST_FINISH: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      div_start    = 1'b0;
      div_dividend = nmag_ff;
      case (state_ff)
         ST_IDLE:   req_ch.ready = 1'b1;
         ST_NSTART: div_start = 1'b1;
         ST_DSTART: begin
            div_start    = 1'b1;
            div_dividend = dmag_ff;
         end
         default: begin
            req_ch.ready = 1'b0;
            div_start    = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      mode_in    = mode_ff;
      lneg_in    = lneg_ff;
      rneg_in    = rneg_ff;
      lmag_in    = lmag_ff;
      ld_in      = ld_ff;
      rmag_in    = rmag_ff;
      rd_in      = rd_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      r_in       = r_ff;
      nneg_in    = nneg_ff;
      nmag_in    = nmag_ff;
      dmag_in    = dmag_ff;
      ga_in      = ga_ff;
      gb_in      = gb_ff;
      gk_in      = gk_ff;
      g_in       = g_ff;
      nq_in      = nq_ff;
      dq_in      = dq_ff;
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      out_lt_in  = out_lt_ff;
      out_eq_in  = out_eq_ff;
      out_st_in  = out_st_ff;
      rsp_num_in = rsp_num_ff;
      rsp_den_in = rsp_den_ff;
      rsp_lt_in  = rsp_lt_ff;
      rsp_eq_in  = rsp_eq_ff;
      rsp_st_in  = rsp_st_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in    = req_ch.mode;
               lneg_in    = ln_neg ^ ldr_neg;
               rneg_in    = rn_neg;
               lmag_in    = ln_mag;
               ld_in      = ldr_mag;
               rmag_in    = rn_mag;
               rd_in      = mag_type'(req_ch.right_den);
               out_num_in = '0;
               out_den_in = DEN_BITS'(1);
               out_lt_in  = 1'b0;
               out_eq_in  = 1'b0;
               out_st_in  = (!undef_mode && zero_err) ? STAT_ZERO : STAT_OK;
            end
         end
         ST_PROD1: p_in = mul_p;
         ST_PROD2: q_in = mul_p;
         ST_PROD3: r_in = mul_p;
         ST_COMBINE: begin
            case (mode_ff)
               MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: begin
                  nneg_in = s_neg;
                  nmag_in = s_mag;
               end
               MODE_MUL, MODE_DIV: begin
                  nneg_in = lneg_ff ^ rneg_ff;
                  nmag_in = p_ff;
               end
               MODE_NEG: begin
                  nneg_in = !lneg_ff;
                  nmag_in = p_ff;
               end
               default: begin
                  nneg_in = lneg_ff;
                  nmag_in = p_ff;
               end
            endcase
            dmag_in   = (mode_ff == MODE_ADD || mode_ff == MODE_SUB) ? r_ff : q_ff;
            ga_in     = nmag_in;
            gb_in     = dmag_in;
            gk_in     = '0;
            out_lt_in = (mode_ff == MODE_CMP) && s_neg && !s_zero;
            out_eq_in = (mode_ff == MODE_CMP) && s_zero;
         end
         ST_GCD: begin
            if (g_done) begin
               g_in = g_val;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (ga_ff > gb_ff) begin
               ga_in = ga_ff - gb_ff;
            end else begin
               gb_in = gb_ff - ga_ff;
            end
         end
         ST_NWAIT: begin
            if (div_done) begin
               nq_in = div_quo;
            end
         end
         ST_DWAIT: begin
            if (div_done) begin
               dq_in = div_quo;
            end
         end
         ST_CHECK: begin
            out_lt_in = 1'b0;
            out_eq_in = 1'b0;
            if (c_ovf) begin
               out_num_in = '0;
               out_den_in = DEN_BITS'(1);
               out_st_in  = STAT_OVF;
            end else begin
               out_num_in = c_num;
               out_den_in = dq_ff[DEN_BITS-1:0];
               out_st_in  = STAT_OK;
            end
         end
         ST_FINISH: begin
            if (load) begin
               rsp_num_in = out_num_ff;
               rsp_den_in = out_den_ff;
               rsp_lt_in  = out_lt_ff;
               rsp_eq_in  = out_eq_ff;
               rsp_st_in  = out_st_ff;
            end
         end
         default: begin
            g_in = g_ff;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      lneg_ff    <= lneg_in;
      rneg_ff    <= rneg_in;
      lmag_ff    <= lmag_in;
      ld_ff      <= ld_in;
      rmag_ff    <= rmag_in;
      rd_ff      <= rd_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      nneg_ff    <= nneg_in;
      nmag_ff    <= nmag_in;
      dmag_ff    <= dmag_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      gk_ff      <= gk_in;
      g_ff       <= g_in;
      nq_ff      <= nq_in;
      dq_ff      <= dq_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_lt_ff  <= out_lt_in;
      out_eq_ff  <= out_eq_in;
      out_st_ff  <= out_st_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_lt_ff  <= rsp_lt_in;
      rsp_eq_ff  <= rsp_eq_in;
      rsp_st_ff  <= rsp_st_in;
   end

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.result_num = rsp_num_ff;
   assign rsp_ch.result_den = rsp_den_ff;
   assign rsp_ch.is_less    = rsp_lt_ff;
   assign rsp_ch.is_equal   = rsp_eq_ff;
   assign rsp_ch.status     = rsp_st_ff;

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start the sequencer");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != STAT_OK |->
         rsp_ch.result_num == '0 && rsp_ch.result_den == DEN_BITS'(1)
         && !rsp_ch.is_less && !rsp_ch.is_equal)
      else $error("error response carries a nonzero fraction or flags");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.result_den != '0)
      else $error("response denominator is zero");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_NWAIT || state_ff == ST_DWAIT)
      else $error("divider finished outside a wait state");

   a_gcd_operand: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> gb_ff != '0)
      else $error("gcd operand dropped to zero");

endmodule

`default_nettype wire

@@ rtl/rau_div.sv @@
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle, for the final reduction
// of numerator and denominator by their common divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rau_pkg::wide_type dividend,
   input  rau_pkg::wide_type divisor,
   output logic              done,
   output rau_pkg::wide_type quotient
);
   import rau_pkg::*;

   localparam int CNT_BITS = $clog2(WIDE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WIDE_BITS - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   wide_type            rem_ff, rem_in;
   wide_type            quo_ff, quo_in;
   wide_type            dsr_ff, dsr_in;
   logic [WIDE_BITS:0]  trial;
   logic [WIDE_BITS:0]  diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[WIDE_BITS-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDE_BITS]) begin
            rem_in = diff[WIDE_BITS-1:0];
            quo_in = {quo_ff[WIDE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDE_BITS-1:0];
            quo_in = {quo_ff[WIDE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");

endmodule

`default_nettype wire
